// ----- rtl/console_line_editor_macros.svh -----
// console_line_editor_macros.svh: assertion macros for the line editor checker
// expects signals named clk and rst_n in the scope of use

`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// same-cycle implication, skipped while in reset
`define CLE_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor check failed");

// next-cycle implication, also checked during reset
`define CLE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line editor check failed");

`endif

// ----- rtl/cle_pkg.sv -----
// cle_pkg: constants, codes and types shared by the line editor modules
// no dependencies

package cle_pkg;

  // line store size and derived widths
  localparam int LINE_MAX = 128;
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 7;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 8;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_RX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // line status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_READY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // characters
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  // result sequence kinds
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_ECHO     = 3'd1;
  localparam logic [2:0] MODE_LINE_END = 3'd2;
  localparam logic [2:0] MODE_ERASE    = 3'd3;
  localparam logic [2:0] MODE_READ     = 3'd4;

  // what the result stage needs to know about one accepted word
  typedef struct packed {
    logic [2:0]          mode;
    logic [1:0]          last_step;
    logic [BYTE_W-1:0]   ch;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic                hit;
  } desc_t;

  // line store access for one accepted word
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- rtl/cle_if.sv -----
// cle_in_if and cle_out_if: valid/ready channels of the line editor
// depends on cle_pkg for field widths

interface cle_in_if;
  logic                          valid;
  logic                          ready;
  logic [cle_pkg::KIND_W-1:0]    kind;
  logic [cle_pkg::BYTE_W-1:0]    rx_byte;
  logic [cle_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, kind, rx_byte, read_index, input ready);
  modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface cle_out_if;
  logic                          valid;
  logic                          ready;
  logic [cle_pkg::BYTE_W-1:0]    echo_char;
  logic                          echo_valid;
  logic [cle_pkg::STATUS_W-1:0]  line_status;
  logic [cle_pkg::LEN_W-1:0]     line_length;
  logic [cle_pkg::BYTE_W-1:0]    read_char;
  logic                          last;

  modport source (output valid, echo_char, echo_valid, line_status, line_length,
                  read_char, last, input ready);
  modport sink   (input valid, echo_char, echo_valid, line_status, line_length,
                  read_char, last, output ready);
endinterface

// ----- rtl/cle_ram.sv -----
// cle_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cle_decode.sv -----
// cle_decode: classifies each accepted word, updates line length and overflow
// depends on cle_pkg

module cle_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [cle_pkg::KIND_W-1:0]  kind,
  input  logic [cle_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [cle_pkg::IDX_W-1:0]   read_index,
  output cle_pkg::desc_t              desc,
  output cle_pkg::ram_req_t           ram_req
);
  import cle_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             printable;
  logic             read_hit;

  assign printable = (rx_byte >= CH_SP) && (rx_byte <= CH_TILDE);
  assign read_hit  = CMP_W'(read_index) < CMP_W'(cnt_r);

  // classify the word and work out the new line state
  always_comb begin
    cnt_nxt           = cnt_r;
    ovf_nxt           = ovf_r;
    desc.mode         = MODE_NONE;
    desc.last_step    = 2'd0;
    desc.ch           = rx_byte;
    desc.status       = STATUS_NONE;
    desc.hit          = 1'b0;
    ram_req.we        = 1'b0;
    ram_req.waddr     = ADDR_W'(cnt_r);
    ram_req.wdata     = rx_byte;
    ram_req.re        = 1'b0;
    ram_req.raddr     = ADDR_W'(read_index);
    case (kind)
      KIND_READ: begin
        desc.mode  = MODE_READ;
        desc.hit   = read_hit;
        ram_req.re = accept;
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      KIND_RX: begin
        if (rx_byte == CH_CR || rx_byte == CH_LF) begin
          desc.mode      = MODE_LINE_END;
          desc.last_step = 2'd1;
          desc.status    = ovf_r ? STATUS_OVERFLOW : STATUS_READY;
        end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
          if (!ovf_r && cnt_r != '0) begin
            cnt_nxt        = cnt_r - CNT_W'(1);
            desc.mode      = MODE_ERASE;
            desc.last_step = 2'd2;
          end
        end else if (printable && !ovf_r) begin
          if (cnt_r >= CNT_W'(LINE_MAX)) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_req.we = accept;
            cnt_nxt    = cnt_r + CNT_W'(1);
            desc.mode  = MODE_ECHO;
          end
        end
      end
      default: begin
      end
    endcase
    desc.length = LEN_W'(cnt_nxt);
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/cle_emit.sv -----
// cle_emit: result register and sequencer that sends one to three result words
// depends on cle_pkg and cle_out_if

module cle_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  cle_pkg::desc_t              desc_in,
  input  logic [cle_pkg::BYTE_W-1:0]  rdata,
  output logic                        take_ok,
  cle_out_if.source                   out_word
);
  import cle_pkg::*;

  logic       valid_r;
  desc_t      desc_r;
  logic [1:0] step_r;
  logic       final_step;
  logic       fire;

  assign final_step = (step_r == desc_r.last_step);
  assign fire       = valid_r && out_word.ready;
  assign take_ok    = !valid_r || (out_word.ready && final_step);

  // control: load a new word or step through its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else if (accept) begin
      valid_r <= 1'b1;
      step_r  <= 2'd0;
    end else if (fire) begin
      if (final_step) begin
        valid_r <= 1'b0;
      end else begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_in;
    end
  end

  // result word fields for the current step
  always_comb begin
    out_word.echo_char   = '0;
    out_word.echo_valid  = 1'b0;
    out_word.line_status = STATUS_NONE;
    out_word.read_char   = '0;
    case (desc_r.mode)
      MODE_ECHO: begin
        out_word.echo_char  = desc_r.ch;
        out_word.echo_valid = 1'b1;
      end
      MODE_LINE_END: begin
        out_word.echo_valid = 1'b1;
        if (final_step) begin
          out_word.echo_char   = CH_LF;
          out_word.line_status = desc_r.status;
        end else begin
          out_word.echo_char = CH_CR;
        end
      end
      MODE_ERASE: begin
        out_word.echo_valid = 1'b1;
        out_word.echo_char  = (step_r == 2'd1) ? CH_SP : CH_BS;
      end
      MODE_READ: begin
        out_word.read_char = desc_r.hit ? rdata : '0;
      end
      default: begin
      end
    endcase
  end

  assign out_word.valid       = valid_r;
  assign out_word.line_length = desc_r.length;
  assign out_word.last        = final_step;

endmodule

// ----- rtl/console_line_editor.sv -----
// console_line_editor: top level of the console line editor
// depends on cle_pkg, cle_if, cle_ram, cle_decode and cle_emit
//
//  channel   | direction | contents
//  ----------+-----------+--------------------------------------------------
//  in_word   | in        | kind, rx_byte, read_index
//  out_word  | out       | echo_char, echo_valid, line_status, line_length,
//            |           | read_char, last
//
// a word is classified and the line state updated in the cycle it is accepted;
// its results leave from the result register one per cycle while out_word is ready;
// a word has one result, two for a line end and three for an erase.
// the next word is taken in the cycle the last result of the previous one goes.
// a stalled out_word holds the result register and stops in_word.ready.
// synchronous reset clears the line length, overflow flag and result valid;
// the line store is not cleared.

module console_line_editor (
  input  logic      clk,
  input  logic      rst_n,
  cle_in_if.sink    in_word,
  cle_out_if.source out_word
);
  import cle_pkg::*;

  logic              accept;
  logic              take_ok;
  desc_t             desc;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] rdata;

  assign in_word.ready = take_ok;
  assign accept        = in_word.valid && take_ok;

  // word classification and line state
  cle_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_word.kind),
    .rx_byte    (in_word.rx_byte),
    .read_index (in_word.read_index),
    .desc       (desc),
    .ram_req    (ram_req)
  );

  // line store
  cle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // result register and sequencing
  cle_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .desc_in  (desc),
    .rdata    (rdata),
    .take_ok  (take_ok),
    .out_word (out_word)
  );

endmodule

// ----- rtl/cle_checker.sv -----
// cle_checker: port-level assertions for the line editor, bound to the top level
// depends on cle_pkg and console_line_editor_macros.svh

`include "console_line_editor_macros.svh"

module cle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic [cle_pkg::BYTE_W-1:0]    echo_char,
  input logic                          echo_valid,
  input logic [cle_pkg::STATUS_W-1:0]  line_status,
  input logic [cle_pkg::LEN_W-1:0]     line_length,
  input logic [cle_pkg::BYTE_W-1:0]    read_char,
  input logic                          last
);
  import cle_pkg::*;

  // nothing leaves straight after reset
  `CLE_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid)
  // no echo character without its flag
  `CLE_ASSERT_IMPLY(a_echo_flag, out_valid && !echo_valid, echo_char == '0)
  // line status only on the closing word
  `CLE_ASSERT_IMPLY(a_status_last, out_valid && line_status != STATUS_NONE, last)
  // a read answer is single and carries no echo
  `CLE_ASSERT_IMPLY(a_read_alone, out_valid && read_char != '0, last && !echo_valid)
  // line length never exceeds the line store
  `CLE_ASSERT_IMPLY(a_length_range, out_valid, line_length <= LEN_W'(LINE_MAX))

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_word.valid),
  .echo_char   (out_word.echo_char),
  .echo_valid  (out_word.echo_valid),
  .line_status (out_word.line_status),
  .line_length (out_word.line_length),
  .read_char   (out_word.read_char),
  .last        (out_word.last)
);
